[design/lrps_pkg.sv]
// Shared constants, control types and pattern tables for the LED ring pattern scaler.
package lrps_pkg;

  localparam int PATTERN_COUNT = 11;
  localparam int RING_SIZE     = 8;
  localparam int CURVE_STEPS   = 13;

  localparam int ROM_PATTERNS  = 11;
  localparam int ROM_CURVE     = 13;

  localparam int LANE_W        = $clog2(RING_SIZE);
  localparam int LAST_PAT      = (PATTERN_COUNT < ROM_PATTERNS ? PATTERN_COUNT : ROM_PATTERNS) - 1;
  localparam int LAST_STEP     = (CURVE_STEPS < ROM_CURVE ? CURVE_STEPS : ROM_CURVE) - 1;

  // Field widths
  localparam int PAT_NUM_W = 8;
  localparam int ROT_W     = 3;
  localparam int BRIGHT_W  = 4;
  localparam int FADE_W    = 8;
  localparam int STEP_W    = 7;
  localparam int CH_W      = 4;
  localparam int PWM_W     = 8;
  localparam int SEL_W     = 4;

  // Shared multiplier
  localparam int MUL_A_W   = 15;
  localparam int MUL_B_W   = 13;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int PCT_W     = 7;
  localparam int WGT_W     = 6;

  // x / 100 == (x * 5243) >> 19 for every x up to 25500
  localparam logic [MUL_B_W-1:0] RECIP_100 = 13'd5243;
  localparam int                 RECIP_SH  = 19;

  localparam logic [WGT_W-1:0] WGT_MAX  = 6'd50;
  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

  localparam logic [STEP_W-1:0] FADE_STEP_RST = 7'd10;

  // Shared unit operations
  localparam logic [2:0] OP_PROD = 3'd0; // fade_amount * fade_step
  localparam logic [2:0] OP_LP   = 3'd1; // led byte * curve percent
  localparam logic [2:0] OP_DIV  = 3'd2; // acc / 100
  localparam logic [2:0] OP_WGT  = 3'd3; // acc * ring weight
  localparam logic [2:0] OP_DIV2 = 3'd4; // acc / 50

  typedef struct packed {
    logic       en;
    logic [2:0] op;
  } lrps_ctl_t;

  function automatic logic [PCT_W-1:0] curve_pct(input logic [BRIGHT_W-1:0] step);
    logic [PCT_W-1:0] p;
    case (step)
      4'd0:    p = 7'd0;
      4'd1:    p = 7'd7;
      4'd2:    p = 7'd8;
      4'd3:    p = 7'd10;
      4'd4:    p = 7'd15;
      4'd5:    p = 7'd20;
      4'd6:    p = 7'd30;
      4'd7:    p = 7'd40;
      4'd8:    p = 7'd50;
      4'd9:    p = 7'd60;
      4'd10:   p = 7'd70;
      4'd11:   p = 7'd80;
      4'd12:   p = 7'd100;
      default: p = 7'd100;
    endcase
    return p;
  endfunction

  function automatic logic pattern_turns(input logic [SEL_W-1:0] pat);
    logic t;
    case (pat)
      4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: t = 1'b1;
      default:                             t = 1'b0;
    endcase
    return t;
  endfunction

  // Bytes run position 0 to 7 from the left of each row
  function automatic logic [PWM_W-1:0] rom_byte(input logic [SEL_W-1:0] pat,
                                                input logic             outer,
                                                input logic [2:0]       idx);
    logic [63:0] inner_row;
    logic [63:0] outer_row;
    logic [63:0] row;
    case (pat)
      4'd0: begin
        inner_row = 64'hFFFF_FFFF_FFFF_FFFF; outer_row = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      4'd1: begin
        inner_row = 64'hFFFF_FFFF_FFFF_FFFF; outer_row = 64'h7F7F_7F7F_7F7F_7F7F;
      end
      4'd2: begin
        inner_row = 64'hFFFF_FFFF_FFFF_FFFF; outer_row = 64'h0000_0000_0000_0000;
      end
      4'd3: begin
        inner_row = 64'h2020_2020_2020_2020; outer_row = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      4'd4: begin
        inner_row = 64'h0000_0000_0000_0000; outer_row = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      4'd5: begin
        inner_row = 64'hFF00_FF00_FF00_FF00; outer_row = 64'hFF00_FF00_FF00_FF00;
      end
      4'd6: begin
        inner_row = 64'hFFFF_0000_FFFF_0000; outer_row = 64'hFFFF_0000_FFFF_0000;
      end
      4'd7: begin
        inner_row = 64'hFF00_0000_FF00_0000; outer_row = 64'hFF00_0000_FF00_0000;
      end
      4'd8: begin
        inner_row = 64'hFF00_0000_0000_0000; outer_row = 64'hFF00_0000_0000_0000;
      end
      4'd9: begin
        inner_row = 64'hFFFF_0000_0000_0000; outer_row = 64'hFFFF_0000_0000_0000;
      end
      4'd10: begin
        inner_row = 64'hFFFF_FFFF_0000_0000; outer_row = 64'hFFFF_FFFF_0000_0000;
      end
      default: begin
        inner_row = 64'h0; outer_row = 64'h0;
      end
    endcase
    row = outer ? outer_row : inner_row;
    return row[63 - 8*idx -: 8];
  endfunction

endpackage

[design/lrps_if.sv]
// Request, result and configuration channel interfaces.
interface lrps_in_if;
  logic                             valid;
  logic                             ready;
  logic [lrps_pkg::PAT_NUM_W-1:0]   pattern_number;
  logic [lrps_pkg::ROT_W-1:0]       rotation;
  logic [lrps_pkg::BRIGHT_W-1:0]    bright_step;
  logic [lrps_pkg::FADE_W-1:0]      fade_amount;

  modport source(output valid, pattern_number, rotation, bright_step, fade_amount,
                 input ready);
  modport sink(input valid, pattern_number, rotation, bright_step, fade_amount,
               output ready);
endinterface

interface lrps_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrps_pkg::CH_W-1:0]     channel;
  logic [lrps_pkg::PWM_W-1:0]    pwm_target;
  logic [lrps_pkg::SEL_W-1:0]    chosen_pattern;
  logic                          last;

  modport source(output valid, channel, pwm_target, chosen_pattern, last, input ready);
  modport sink(input valid, channel, pwm_target, chosen_pattern, last, output ready);
endinterface

interface lrps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lrps_pkg::STEP_W-1:0]   fade_step;

  modport source(output valid, fade_step, input ready);
  modport sink(input valid, fade_step, output ready);
endinterface

[design/lrps_scale_unit.sv]
// Shared multiplier with accumulator: weight product, scaling and divides by 100 and 50.
module lrps_scale_unit (
  input  logic                               clk,
  input  lrps_pkg::lrps_ctl_t                ctl,
  input  logic [lrps_pkg::FADE_W-1:0]        fade_amount,
  input  logic [lrps_pkg::STEP_W-1:0]        fade_step,
  input  logic [lrps_pkg::PWM_W-1:0]         led,
  input  logic [lrps_pkg::PCT_W-1:0]         pct,
  input  logic [lrps_pkg::WGT_W-1:0]         weight,
  output logic [lrps_pkg::MUL_A_W-1:0]       acc,
  output logic [lrps_pkg::MUL_A_W-1:0]       res
);

  logic [lrps_pkg::MUL_A_W-1:0] acc_r;
  logic [lrps_pkg::MUL_A_W-1:0] op_a;
  logic [lrps_pkg::MUL_B_W-1:0] op_b;
  logic [lrps_pkg::MUL_P_W-1:0] prod;
  logic [lrps_pkg::MUL_P_W-1:0] prod_sh;

  always_comb begin
    case (ctl.op)
      lrps_pkg::OP_PROD: begin
        op_a = lrps_pkg::MUL_A_W'(fade_amount);
        op_b = lrps_pkg::MUL_B_W'(fade_step);
      end
      lrps_pkg::OP_LP: begin
        op_a = lrps_pkg::MUL_A_W'(led);
        op_b = lrps_pkg::MUL_B_W'(pct);
      end
      lrps_pkg::OP_DIV: begin
        op_a = acc_r;
        op_b = lrps_pkg::RECIP_100;
      end
      lrps_pkg::OP_WGT: begin
        op_a = acc_r;
        op_b = lrps_pkg::MUL_B_W'(weight);
      end
      lrps_pkg::OP_DIV2: begin
        // x / 50 == 2x / 100
        op_a = {acc_r[lrps_pkg::MUL_A_W-2:0], 1'b0};
        op_b = lrps_pkg::RECIP_100;
      end
      default: begin
        op_a = acc_r;
        op_b = '0;
      end
    endcase
  end

  assign prod    = lrps_pkg::MUL_P_W'(op_a) * lrps_pkg::MUL_P_W'(op_b);
  assign prod_sh = prod >> lrps_pkg::RECIP_SH;

  always_comb begin
    case (ctl.op)
      lrps_pkg::OP_DIV, lrps_pkg::OP_DIV2: res = prod_sh[lrps_pkg::MUL_A_W-1:0];
      default:                             res = prod[lrps_pkg::MUL_A_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= res;
    end
  end

  assign acc = acc_r;

endmodule

[design/led_ring_pattern_scaler.sv]
// Top level of the LED ring pattern scaler: sequencer, ring weights and result register.
//
// A request picks one of eleven built-in patterns (numbers past the last pick the last)
// and yields sixteen PWM targets, inner 0, outer 0, inner 1, outer 1 and so on, each the
// pattern byte scaled by the brightness-curve percent and by its ring's fade weight.
// Every request runs through one shared multiplier: acceptance forms fade_amount times
// fade_step, state ST_WGT turns that into the two ring weights, and then each target takes
// four multiplier passes (byte times percent, divide by 100, times weight, divide by 50).
// A result that waits on out_ch.ready holds the sequencer until it is taken. in_ch.ready is
// high only between requests, but the next request may be taken while the final result
// of the previous one is still waiting. cfg_ch.ready is always high; fade_step resets to 10.
module led_ring_pattern_scaler (
  input  logic             clk,
  input  logic             rst_n,
  lrps_in_if.sink          in_ch,
  lrps_out_if.source       out_ch,
  lrps_cfg_if.sink         cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WGT  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  localparam int SUM_W = lrps_pkg::LANE_W + 1;

  logic [1:0]                         state_r, state_nxt;
  logic [1:0]                         phase_r, phase_nxt;
  logic [lrps_pkg::LANE_W-1:0]        lane_r, lane_nxt;
  logic                               ring_r, ring_nxt;
  logic [lrps_pkg::STEP_W-1:0]        fade_step_r;
  logic [lrps_pkg::SEL_W-1:0]         sel_r;
  logic [lrps_pkg::ROT_W-1:0]         rot_r;
  logic                               turns_r;
  logic [lrps_pkg::PCT_W-1:0]         pct_r;
  logic [lrps_pkg::WGT_W-1:0]         w_in_r;
  logic [lrps_pkg::WGT_W-1:0]         w_out_r;

  logic                               out_valid_r;
  logic [lrps_pkg::CH_W-1:0]          out_channel_r;
  logic [lrps_pkg::PWM_W-1:0]         out_pwm_r;
  logic [lrps_pkg::SEL_W-1:0]         out_sel_r;
  logic                               out_last_r;

  logic                               in_acc;
  logic                               slot_free;
  logic                               emit;
  logic                               lane_last;
  logic [lrps_pkg::SEL_W-1:0]         sel_in;
  logic [lrps_pkg::BRIGHT_W-1:0]      bright_clamped;
  logic [SUM_W-1:0]                   rot_sum;
  logic [lrps_pkg::LANE_W-1:0]        pos;
  logic [lrps_pkg::PWM_W-1:0]         led;
  logic [lrps_pkg::WGT_W-1:0]         weight;
  logic [lrps_pkg::MUL_A_W-1:0]       acc;
  logic [lrps_pkg::MUL_A_W-1:0]       res;
  logic [lrps_pkg::MUL_A_W-1:0]       diff;
  logic [lrps_pkg::WGT_W-1:0]         w_in_nxt;
  logic [lrps_pkg::WGT_W-1:0]         w_out_nxt;
  lrps_pkg::lrps_ctl_t                ctl;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign sel_in = (in_ch.pattern_number > lrps_pkg::PAT_NUM_W'(lrps_pkg::LAST_PAT)) ?
                  lrps_pkg::SEL_W'(lrps_pkg::LAST_PAT) :
                  in_ch.pattern_number[lrps_pkg::SEL_W-1:0];
  assign bright_clamped = (in_ch.bright_step > lrps_pkg::BRIGHT_W'(lrps_pkg::LAST_STEP)) ?
                          lrps_pkg::BRIGHT_W'(lrps_pkg::LAST_STEP) : in_ch.bright_step;

  // rotating patterns read lane + rotation around the ring
  assign rot_sum = SUM_W'(lane_r) + SUM_W'(rot_r);
  assign pos     = turns_r ? lrps_pkg::LANE_W'(rot_sum % lrps_pkg::RING_SIZE) : lane_r;
  assign led     = lrps_pkg::rom_byte(sel_r, ring_r, 3'(pos));
  assign weight  = ring_r ? w_out_r : w_in_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit      = (state_r == ST_RUN) && (phase_r == 2'd3) && slot_free;
  assign lane_last = (lane_r == lrps_pkg::LANE_W'(lrps_pkg::RING_SIZE - 1));

  always_comb begin
    ctl.en = 1'b0;
    ctl.op = lrps_pkg::OP_PROD;
    case (state_r)
      ST_IDLE: begin
        ctl.en = in_acc;
        ctl.op = lrps_pkg::OP_PROD;
      end
      ST_RUN: begin
        ctl.en = (phase_r != 2'd3) || slot_free;
        case (phase_r)
          2'd0:    ctl.op = lrps_pkg::OP_LP;
          2'd1:    ctl.op = lrps_pkg::OP_DIV;
          2'd2:    ctl.op = lrps_pkg::OP_WGT;
          default: ctl.op = lrps_pkg::OP_DIV2;
        endcase
      end
      default: begin
        ctl.en = 1'b0;
        ctl.op = lrps_pkg::OP_PROD;
      end
    endcase
  end

  lrps_scale_unit u_scale (
    .clk         (clk),
    .ctl         (ctl),
    .fade_amount (in_ch.fade_amount),
    .fade_step   (fade_step_r),
    .led         (led),
    .pct         (pct_r),
    .weight      (weight),
    .acc         (acc),
    .res         (res)
  );

  // ring weights from the fade product held in acc
  assign diff      = lrps_pkg::MUL_A_W'(lrps_pkg::FULL_PCT) - acc;
  assign w_in_nxt  = (acc > lrps_pkg::MUL_A_W'(lrps_pkg::WGT_MAX)) ?
                     lrps_pkg::WGT_MAX : acc[lrps_pkg::WGT_W-1:0];
  assign w_out_nxt = (acc > lrps_pkg::MUL_A_W'(lrps_pkg::FULL_PCT)) ? lrps_pkg::WGT_MAX :
                     (diff > lrps_pkg::MUL_A_W'(lrps_pkg::WGT_MAX)) ? lrps_pkg::WGT_MAX :
                     diff[lrps_pkg::WGT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    lane_nxt  = lane_r;
    ring_nxt  = ring_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_WGT;
        end
      end
      ST_WGT: begin
        state_nxt = ST_RUN;
        phase_nxt = 2'd0;
        lane_nxt  = '0;
        ring_nxt  = 1'b0;
      end
      ST_RUN: begin
        if (phase_r != 2'd3) begin
          phase_nxt = phase_r + 2'd1;
        end else if (slot_free) begin
          phase_nxt = 2'd0;
          if (!ring_r) begin
            ring_nxt = 1'b1;
          end else begin
            ring_nxt = 1'b0;
            lane_nxt = lane_r + 1'b1;
            if (lane_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 2'd0;
      lane_r      <= '0;
      ring_r      <= 1'b0;
      fade_step_r <= lrps_pkg::FADE_STEP_RST;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      lane_r  <= lane_nxt;
      ring_r  <= ring_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        fade_step_r <= cfg_ch.fade_step;
      end
      if (in_acc) begin
        sel_r <= sel_in;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rot_r   <= in_ch.rotation;
      turns_r <= lrps_pkg::pattern_turns(sel_in);
      pct_r   <= lrps_pkg::curve_pct(bright_clamped);
    end
    if (state_r == ST_WGT) begin
      w_in_r  <= w_in_nxt;
      w_out_r <= w_out_nxt;
    end
    if (emit) begin
      out_channel_r <= ring_r ? lrps_pkg::CH_W'(lane_r) + lrps_pkg::CH_W'(lrps_pkg::RING_SIZE)
                              : lrps_pkg::CH_W'(lane_r);
      out_pwm_r     <= res[lrps_pkg::PWM_W-1:0];
      out_sel_r     <= sel_r;
      out_last_r    <= ring_r && lane_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel        = out_channel_r;
  assign out_ch.pwm_target     = out_pwm_r;
  assign out_ch.chosen_pattern = out_sel_r;
  assign out_ch.last           = out_last_r;

endmodule

[dv/tb_led_ring_pattern_scaler.sv]
// Self-checking testbench for the LED ring pattern scaler: directed table, then random requests.
`timescale 1ns / 1ps

module tb_led_ring_pattern_scaler;

  localparam int TARGETS_PER_REQ = 2 * lrps_pkg::RING_SIZE;
  localparam int FIRST_TURNING   = 5;    // patterns from here on rotate
  localparam int ROM_RING        = 8;
  localparam int LONG_HOLD       = 400;  // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES    = 80;   // a little over one request's latency
  localparam int PHASE_REQS      = 26;
  localparam int PHASES          = 6;

  typedef struct packed {
    logic [lrps_pkg::PAT_NUM_W-1:0] pattern_number;
    logic [lrps_pkg::ROT_W-1:0]     rotation;
    logic [lrps_pkg::BRIGHT_W-1:0]  bright_step;
    logic [lrps_pkg::FADE_W-1:0]    fade_amount;
  } led_request_t;

  typedef struct packed {
    logic [lrps_pkg::CH_W-1:0]  channel;
    logic [lrps_pkg::PWM_W-1:0] pwm_target;
    logic [lrps_pkg::SEL_W-1:0] chosen_pattern;
    logic                       last;
  } led_target_t;

  // Directed row: request plus, where typed, the selected pattern and lane 0 targets
  typedef struct packed {
    led_request_t               req;
    logic                       typed;
    logic [lrps_pkg::SEL_W-1:0] sel;
    logic [lrps_pkg::PWM_W-1:0] inner0;
    logic [lrps_pkg::PWM_W-1:0] outer0;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  localparam int unsigned BRIGHT_PCT [13] = '{0, 7, 8, 10, 15, 20, 30, 40, 50, 60, 70, 80, 100};

  logic clk = 1'b0;
  logic rst_n;

  lrps_in_if  in_ch ();
  lrps_out_if out_ch ();
  lrps_cfg_if cfg_ch ();

  led_ring_pattern_scaler DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  led_target_t                 targets_due [$];
  logic [lrps_pkg::STEP_W-1:0] fade_step_now;
  int unsigned                 src_idle_pct;
  int unsigned                 snk_idle_pct;
  bit                          hold_request;
  int unsigned                 hold_left;
  int unsigned                 mismatches;
  int unsigned                 requests_sent;
  int unsigned                 targets_checked;
  int unsigned                 settings_used;
  dir_row_t                    dir_tab [DIR_ROWS];

  task automatic report_mismatch(input string msg);
    if (mismatches < 40)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // LED byte of a pattern at a ring position
  function automatic int unsigned ring_level(input logic [lrps_pkg::SEL_W-1:0] pat,
                                             input bit outer, input int unsigned pos);
    logic [7:0]  lit;
    int unsigned lvl;
    lit = 8'h00;
    case (pat)
      4'd0:    lvl = 255;
      4'd1:    lvl = outer ? 127 : 255;
      4'd2:    lvl = outer ? 0 : 255;
      4'd3:    lvl = outer ? 255 : 32;
      4'd4:    lvl = outer ? 255 : 0;
      default: begin
        case (pat)
          4'd5:    lit = 8'h55;
          4'd6:    lit = 8'h33;
          4'd7:    lit = 8'h11;
          4'd8:    lit = 8'h01;
          4'd9:    lit = 8'h03;
          default: lit = 8'h0F;
        endcase
        lvl = lit[pos] ? 255 : 0;
      end
    endcase
    return lvl;
  endfunction

  function automatic led_target_t predict_target(input led_request_t r,
                                                 input logic [lrps_pkg::STEP_W-1:0] step,
                                                 input int unsigned lane, input bit outer);
    led_target_t                t;
    logic [lrps_pkg::SEL_W-1:0] pat;
    int unsigned                bs, prod, wgt, pos, lvl;
    pat  = (r.pattern_number > lrps_pkg::LAST_PAT) ? lrps_pkg::SEL_W'(lrps_pkg::LAST_PAT)
                                                   : r.pattern_number[lrps_pkg::SEL_W-1:0];
    bs   = (r.bright_step > lrps_pkg::LAST_STEP) ? lrps_pkg::LAST_STEP : r.bright_step;
    prod = int'(r.fade_amount) * int'(step);
    if (!outer)
      wgt = (prod > 50) ? 50 : prod;
    else if (prod > 100)
      wgt = 50;
    else
      wgt = ((100 - prod) > 50) ? 50 : 100 - prod;
    pos = (pat >= FIRST_TURNING) ? (lane + r.rotation) % lrps_pkg::RING_SIZE : lane;
    lvl = ring_level(pat, outer, pos % ROM_RING);
    t.channel        = lrps_pkg::CH_W'(outer ? lane + lrps_pkg::RING_SIZE : lane);
    t.pwm_target     = lrps_pkg::PWM_W'((((lvl * BRIGHT_PCT[bs]) / 100) * wgt) / 50);
    t.chosen_pattern = pat;
    t.last           = outer && (lane == lrps_pkg::RING_SIZE - 1);
    return t;
  endfunction

  // Offer one request; on acceptance queue its sixteen targets
  task automatic send_request(input dir_row_t row);
    led_target_t t;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.pattern_number = row.req.pattern_number;
    in_ch.rotation       = row.req.rotation;
    in_ch.bright_step    = row.req.bright_step;
    in_ch.fade_amount    = row.req.fade_amount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    for (int unsigned k = 0; k < lrps_pkg::RING_SIZE; k++) begin
      for (int o = 0; o < 2; o++) begin
        t = predict_target(row.req, fade_step_now, k, o[0]);
        if (row.typed) begin
          t.chosen_pattern = row.sel;
          if (k == 0) t.pwm_target = o[0] ? row.outer0 : row.inner0;
        end
        targets_due.push_back(t);
      end
    end
    requests_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (targets_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_fade_step(input logic [lrps_pkg::STEP_W-1:0] v);
    cfg_ch.valid     = 1'b1;
    cfg_ch.fade_step = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    fade_step_now = v;
    settings_used++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic dir_row_t random_row();
    dir_row_t r;
    r = '0;
    // mostly valid patterns with the odd clamp, mostly small fades where the weights bend
    if ($urandom_range(0, 5) == 0)
      r.req.pattern_number = lrps_pkg::PAT_NUM_W'($urandom_range(0, 255));
    else
      r.req.pattern_number = lrps_pkg::PAT_NUM_W'($urandom_range(0, lrps_pkg::PATTERN_COUNT));
    r.req.rotation    = lrps_pkg::ROT_W'($urandom_range(0, 7));
    r.req.bright_step = lrps_pkg::BRIGHT_W'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0)
      r.req.fade_amount = lrps_pkg::FADE_W'($urandom_range(0, 255));
    else
      r.req.fade_amount = lrps_pkg::FADE_W'($urandom_range(0, 15));
    return r;
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    led_target_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (targets_due.size() == 0) begin
        report_mismatch($sformatf("unexpected target ch=%0d pwm=%0d pat=%0d last=%0b",
                                  out_ch.channel, out_ch.pwm_target, out_ch.chosen_pattern,
                                  out_ch.last));
      end else begin
        want = targets_due.pop_front();
        if (out_ch.channel !== want.channel || out_ch.pwm_target !== want.pwm_target ||
            out_ch.chosen_pattern !== want.chosen_pattern || out_ch.last !== want.last)
          report_mismatch($sformatf("ch=%0d/%0d pwm=%0d/%0d pat=%0d/%0d last=%0b/%0b (got/want)",
                                    out_ch.channel, want.channel, out_ch.pwm_target,
                                    want.pwm_target, out_ch.chosen_pattern, want.chosen_pattern,
                                    out_ch.last, want.last));
        targets_checked++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("led_ring_pattern_scaler regression: fail");
    $finish;
  end

  initial begin
    logic [lrps_pkg::STEP_W-1:0] steps [PHASES];
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.pattern_number = '0;
    in_ch.rotation       = '0;
    in_ch.bright_step    = '0;
    in_ch.fade_amount    = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.fade_step     = '0;
    fade_step_now        = lrps_pkg::FADE_STEP_RST;
    src_idle_pct         = 38;
    snk_idle_pct         = 48;
    hold_request         = 1'b0;
    mismatches           = 0;
    requests_sent        = 0;
    targets_checked      = 0;
    settings_used        = 1;

    // fade_step at its reset value of 10 for the whole table
    //            pattern  rot   bright  fade    typed  sel    inner0  outer0
    dir_tab = '{
      '{'{8'd0,   3'd0, 4'd12, 8'd5},   1'b1, 4'd0,  8'd255, 8'd255},
      '{'{8'd0,   3'd0, 4'd0,  8'd5},   1'b1, 4'd0,  8'd0,   8'd0},
      '{'{8'd255, 3'd0, 4'd15, 8'd5},   1'b1, 4'd10, 8'd255, 8'd255},  // clamp, saturate
      '{'{8'd11,  3'd0, 4'd13, 8'd5},   1'b1, 4'd10, 8'd255, 8'd255},
      '{'{8'd0,   3'd0, 4'd12, 8'd0},   1'b1, 4'd0,  8'd0,   8'd255},  // inner dark
      '{'{8'd0,   3'd0, 4'd12, 8'd255}, 1'b1, 4'd0,  8'd255, 8'd255},
      '{'{8'd0,   3'd0, 4'd12, 8'd10},  1'b1, 4'd0,  8'd255, 8'd0},    // product exactly 100
      '{'{8'd0,   3'd0, 4'd12, 8'd7},   1'b1, 4'd0,  8'd255, 8'd153},
      '{'{8'd0,   3'd0, 4'd12, 8'd11},  1'b1, 4'd0,  8'd255, 8'd255},  // product past 100
      '{'{8'd0,   3'd0, 4'd12, 8'd3},   1'b1, 4'd0,  8'd153, 8'd255},
      '{'{8'd1,   3'd3, 4'd8,  8'd4},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd2,   3'd5, 4'd11, 8'd6},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd3,   3'd0, 4'd9,  8'd2},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd4,   3'd7, 4'd12, 8'd8},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd5,   3'd1, 4'd12, 8'd5},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd6,   3'd2, 4'd10, 8'd9},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd7,   3'd3, 4'd7,  8'd1},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd8,   3'd7, 4'd14, 8'd5},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd9,   3'd4, 4'd12, 8'd6},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd10,  3'd6, 4'd5,  8'd4},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd5,   3'd0, 4'd1,  8'd5},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd10,  3'd7, 4'd2,  8'd5},   1'b0, 4'd0,  8'd0,   8'd0},
      '{'{8'd3,   3'd5, 4'd3,  8'd5},   1'b0, 4'd0,  8'd0,   8'd0},  // fixed ring ignores rotation
      '{'{8'd1,   3'd7, 4'd4,  8'd100}, 1'b0, 4'd0,  8'd0,   8'd0}
    };

    steps[0] = 7'd100;
    steps[1] = 7'd0;
    steps[2] = lrps_pkg::STEP_W'($urandom_range(2, 99));
    steps[3] = 7'd1;
    steps[4] = 7'd50;
    steps[5] = 7'd7;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_tab[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_fade_step(steps[ph]);
      if (ph < 2) begin
        src_idle_pct = 38;
        snk_idle_pct = 48;
      end else if (ph < 4) begin
        src_idle_pct = 48;
        snk_idle_pct = 38;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // receiver stalls while requests keep coming, so the input backs up
      if (ph == 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_REQS; n++)
        send_request(random_row());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests over %0d fade_step settings, %0d targets checked",
             requests_sent, settings_used, targets_checked);
    $display("Covered clamped patterns, saturated brightness, ring weight limits and stalls");
    if (mismatches == 0 && targets_due.size() == 0) begin
      $display("led_ring_pattern_scaler regression: pass");
    end else begin
      $display("led_ring_pattern_scaler regression: fail");
    end
    $finish;
  end

endmodule
